@@ sv/all_pairs_shortest_path_assert.svh @@
// Assertion macros for the all-pairs shortest path block.
// Used by the port checker; needs clk and rst_n in the scope where a macro is expanded.
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/apsp_pkg.sv @@
// Shared constants and types of the all-pairs shortest path block.
// No dependencies; the interfaces, the top level and the checker import this package.
package apsp_pkg;

    // Default sizes of the distance matrix and of one distance.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int DIST_WIDTH_DEF   = 48;

    // Fixed widths of the item and result fields.
    localparam int IDX_FIELD_W = 6;
    localparam int WEIGHT_W    = 32;
    localparam int OUT_DIST_W  = 48;
    localparam int VCOUNT_W    = 7;

    typedef logic [IDX_FIELD_W-1:0]        idx_field_t;
    typedef logic signed [WEIGHT_W-1:0]    weight_t;
    typedef logic signed [OUT_DIST_W-1:0]  out_dist_t;
    typedef logic [VCOUNT_W-1:0]           vcount_t;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

@@ sv/apsp_if.sv @@
// Handshake channels of the all-pairs shortest path block: items, results and
// the vertex count register write. Depends on apsp_pkg.
interface apsp_req_if;
    import apsp_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    idx_field_t row;
    idx_field_t col;
    weight_t    weight;
    logic       weight_infinite;
    logic       last_load;

    modport source (output valid, kind, row, col, weight, weight_infinite, last_load,
                    input ready);
    modport sink   (input valid, kind, row, col, weight, weight_infinite, last_load,
                    output ready);
endinterface

interface apsp_rsp_if;
    import apsp_pkg::*;

    logic      valid;
    logic      ready;
    out_dist_t distance;
    logic      distance_infinite;
    logic      negative_cycle;
    logic      is_status;

    modport source (output valid, distance, distance_infinite, negative_cycle, is_status,
                    input ready);
    modport sink   (input valid, distance, distance_infinite, negative_cycle, is_status,
                    output ready);
endinterface

interface apsp_cfg_if;
    import apsp_pkg::*;

    logic    valid;
    logic    ready;
    vcount_t vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

@@ sv/apsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/all_pairs_shortest_path.sv @@
// Top level of the all-pairs shortest path block (Floyd-Warshall).
// Depends on apsp_pkg, the channel interfaces in apsp_if.sv and apsp_ram.

// Load items write one matrix entry. The load marked last starts the
// relaxation, during which no item is accepted; the relaxation walks every
// pivot and row, fetching the row-to-pivot entry, and every column of a row
// whose entry is finite, then checks the n diagonal entries before the status
// result is loaded, n being the clamped vertex count. The column rate is set
// by the matrix RAM, which is kept as two copies written together so that the
// pivot-row entry and the updated entry are read in the same cycle. A read item
// first accesses the RAM, then loads the output register once it is free.
// A reset does not clear the matrix; every entry must be loaded before it is used.
module all_pairs_shortest_path #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
    parameter int DIST_WIDTH   = apsp_pkg::DIST_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    apsp_cfg_if.sink          cfg,
    apsp_req_if.sink          req,
    apsp_rsp_if.source        rsp
);
    import apsp_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = DIST_WIDTH + 1;
    localparam int EXT_W = (DIST_WIDTH > WEIGHT_W) ? DIST_WIDTH : WEIGHT_W;

    localparam logic signed [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
    localparam logic signed [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] EXT_MAX = EXT_W'(DIST_MAX);
    localparam logic signed [EXT_W-1:0] EXT_MIN = EXT_W'(DIST_MIN);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_VERTICES - 1);

    // Controller states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD_RESP = 3'd1;
    localparam logic [2:0] S_START   = 3'd2;
    localparam logic [2:0] S_ROW     = 3'd3;
    localparam logic [2:0] S_COL     = 3'd4;
    localparam logic [2:0] S_DIAG    = 3'd5;
    localparam logic [2:0] S_STATUS  = 3'd6;

    // Matrix entry address: row times the row pitch plus column.
    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        cell_addr = AW'(AW'(r) * AW'(MAX_VERTICES) + AW'(c));
    endfunction

    logic [2:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             k_reg, k_next;
    logic [IDX_W-1:0]             i_reg, i_next;
    logic [IDX_W-1:0]             j_reg, j_next;
    logic [IDX_W-1:0]             n_m1_reg, n_m1_next;
    logic signed [DIST_WIDTH-1:0] ik_reg, ik_next;
    logic                         neg_reg, neg_next;
    logic                         oor_reg, oor_next;
    vcount_t                      vcount_reg;

    logic             out_valid_reg;
    out_dist_t        out_dist_reg;
    logic             out_inf_reg;
    logic             out_neg_reg;
    logic             out_status_reg;
    logic             out_load;
    out_dist_t        out_dist_next;
    logic             out_inf_next;
    logic             out_status_next;
    logic             out_free;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             re_a, re_b;
    logic [AW-1:0]    raddr_a, raddr_b;
    logic [ENT_W-1:0] rdata_a, rdata_b;

    // Matrix storage: two copies, always written together.
    apsp_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (re_a),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    apsp_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (re_b),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // Read data split into infinity mark and distance.
    logic                         a_inf, b_inf;
    logic signed [DIST_WIDTH-1:0] a_val, b_val;
    assign a_inf = rdata_a[DIST_WIDTH];
    assign a_val = signed'(rdata_a[DIST_WIDTH-1:0]);
    assign b_inf = rdata_b[DIST_WIDTH];
    assign b_val = signed'(rdata_b[DIST_WIDTH-1:0]);

    // Item decode: range check, index narrowing and weight saturation.
    logic                         ld_in_range;
    logic [IDX_W-1:0]             ld_row, ld_col;
    logic signed [EXT_W-1:0]      w_ext;
    logic signed [DIST_WIDTH-1:0] w_sat;
    logic [IDX_W-1:0]             n_m1_calc;

    assign ld_in_range = (int'(req.row) < MAX_VERTICES) && (int'(req.col) < MAX_VERTICES);
    assign ld_row      = IDX_W'(req.row);
    assign ld_col      = IDX_W'(req.col);
    assign w_ext       = EXT_W'(req.weight);

    always_comb
    begin
        if (w_ext > EXT_MAX)
        begin
            w_sat = DIST_MAX;
        end
        else if (w_ext < EXT_MIN)
        begin
            w_sat = DIST_MIN;
        end
        else
        begin
            w_sat = DIST_WIDTH'(w_ext);
        end
    end

    // Highest vertex index in use, from the clamped vertex count.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_m1_calc = '0;
        end
        else if (int'(vcount_reg) > MAX_VERTICES)
        begin
            n_m1_calc = IDX_TOP;
        end
        else
        begin
            n_m1_calc = IDX_W'(vcount_reg - VCOUNT_W'(1));
        end
    end

    // Saturating path sum through the pivot and the relaxation test.
    logic signed [DIST_WIDTH:0]   sum_ext;
    logic signed [DIST_WIDTH-1:0] s_sat;
    logic                         better;

    assign sum_ext = {ik_reg[DIST_WIDTH-1], ik_reg} + {a_val[DIST_WIDTH-1], a_val};

    always_comb
    begin
        if (sum_ext[DIST_WIDTH] != sum_ext[DIST_WIDTH-1])
        begin
            s_sat = sum_ext[DIST_WIDTH] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            s_sat = sum_ext[DIST_WIDTH-1:0];
        end
    end

    assign better = b_inf || (s_sat < b_val);

    // Step to the next row, the next pivot or the diagonal check.
    logic             last_i, last_k, last_j;
    logic [2:0]       adv_state;
    logic [IDX_W-1:0] adv_i, adv_k;
    logic [AW-1:0]    adv_addr;
    logic             adv_diag;

    assign last_i = (i_reg == n_m1_reg);
    assign last_k = (k_reg == n_m1_reg);
    assign last_j = (j_reg == n_m1_reg);

    always_comb
    begin
        adv_diag = 1'b0;
        adv_k    = k_reg;
        adv_i    = i_reg + IDX_ONE;
        adv_addr = cell_addr(i_reg + IDX_ONE, k_reg);
        adv_state = S_ROW;
        if (last_i)
        begin
            adv_i = '0;
            if (last_k)
            begin
                adv_k     = '0;
                adv_addr  = cell_addr('0, '0);
                adv_state = S_DIAG;
                adv_diag  = 1'b1;
            end
            else
            begin
                adv_k    = k_reg + IDX_ONE;
                adv_addr = cell_addr('0, k_reg + IDX_ONE);
            end
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Controller: item handling, relaxation sweep and result loading.
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_m1_next       = n_m1_reg;
        ik_next         = ik_reg;
        neg_next        = neg_reg;
        oor_next        = oor_reg;
        mem_we          = 1'b0;
        mem_waddr       = cell_addr(i_reg, j_reg);
        mem_wdata       = {1'b0, s_sat};
        re_a            = 1'b0;
        raddr_a         = cell_addr(ld_row, ld_col);
        re_b            = 1'b0;
        raddr_b         = cell_addr(i_reg, j_reg + IDX_ONE);
        out_load        = 1'b0;
        out_dist_next   = '0;
        out_inf_next    = 1'b0;
        out_status_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind == KIND_READ)
                    begin
                        re_a       = 1'b1;
                        oor_next   = !ld_in_range;
                        state_next = S_RD_RESP;
                    end
                    else
                    begin
                        mem_we    = ld_in_range;
                        mem_waddr = cell_addr(ld_row, ld_col);
                        mem_wdata = req.weight_infinite ? {1'b1, {DIST_WIDTH{1'b0}}}
                                                        : {1'b0, w_sat};
                        if (req.last_load)
                        begin
                            n_m1_next  = n_m1_calc;
                            k_next     = '0;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = S_START;
                        end
                    end
                end
            end

            S_RD_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_dist_next = oor_reg ? '0 : OUT_DIST_W'(a_val);
                    out_inf_next  = oor_reg || a_inf;
                    state_next    = S_IDLE;
                end
            end

            S_START:
            begin
                re_a       = 1'b1;
                raddr_a    = cell_addr(i_reg, k_reg);
                state_next = S_ROW;
            end

            S_ROW:
            begin
                if (a_inf)
                begin
                    // Row cannot reach the pivot: skip it.
                    re_a       = 1'b1;
                    raddr_a    = adv_addr;
                    i_next     = adv_i;
                    k_next     = adv_k;
                    state_next = adv_state;
                    if (adv_diag)
                    begin
                        neg_next = 1'b0;
                    end
                end
                else
                begin
                    ik_next    = a_val;
                    j_next     = '0;
                    re_a       = 1'b1;
                    raddr_a    = cell_addr(k_reg, '0);
                    re_b       = 1'b1;
                    raddr_b    = cell_addr(i_reg, '0);
                    state_next = S_COL;
                end
            end

            S_COL:
            begin
                // Port A holds pivot row entry, port B the entry under update.
                if (!a_inf && better)
                begin
                    mem_we = 1'b1;
                    if (j_reg == k_reg)
                    begin
                        ik_next = s_sat;
                    end
                end
                if (last_j)
                begin
                    re_a       = 1'b1;
                    raddr_a    = adv_addr;
                    i_next     = adv_i;
                    k_next     = adv_k;
                    state_next = adv_state;
                    if (adv_diag)
                    begin
                        neg_next = 1'b0;
                    end
                end
                else
                begin
                    j_next  = j_reg + IDX_ONE;
                    re_a    = 1'b1;
                    raddr_a = cell_addr(k_reg, j_reg + IDX_ONE);
                    re_b    = 1'b1;
                end
            end

            S_DIAG:
            begin
                if (!a_inf && (a_val < 0))
                begin
                    neg_next = 1'b1;
                end
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = S_STATUS;
                end
                else
                begin
                    i_next  = i_reg + IDX_ONE;
                    re_a    = 1'b1;
                    raddr_a = cell_addr(i_reg + IDX_ONE, i_reg + IDX_ONE);
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            n_m1_reg   <= '0;
            neg_reg    <= 1'b0;
            oor_reg    <= 1'b0;
            vcount_reg <= VCOUNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_m1_reg  <= n_m1_next;
            neg_reg   <= neg_next;
            oor_reg   <= oor_next;
            if (cfg.valid)
            begin
                vcount_reg <= cfg.vertex_count;
            end
        end
    end

    // Row-to-pivot distance held for the column sweep.
    always_ff @(posedge clk)
    begin
        ik_reg <= ik_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg   <= out_dist_next;
            out_inf_reg    <= out_inf_next;
            out_neg_reg    <= neg_reg;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.distance          = out_dist_reg;
    assign rsp.distance_infinite = out_inf_reg;
    assign rsp.negative_cycle    = out_neg_reg;
    assign rsp.is_status         = out_status_reg;

endmodule

@@ sv/apsp_checker.sv @@
// Port checker for the all-pairs shortest path block, bound to the top level.
// Depends on apsp_pkg and the macros in all_pairs_shortest_path_assert.svh.
`include "all_pairs_shortest_path_assert.svh"

module apsp_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   req_kind,
    input logic                   req_last_load,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input apsp_pkg::out_dist_t    rsp_distance,
    input logic                   rsp_distance_infinite,
    input logic                   rsp_is_status
);
    import apsp_pkg::*;

    // A result that is not taken stays offered.
    `APSP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    // The last load starts the relaxation, so no item is taken in the next cycle.
    `APSP_ASSERT_NXT(a_last_load_busy, req_valid && req_ready && (req_kind == KIND_LOAD) && req_last_load, !req_ready, "item taken right after last load")

    // A read item occupies the block for its RAM access.
    `APSP_ASSERT_NXT(a_read_busy, req_valid && req_ready && (req_kind == KIND_READ), !req_ready, "item taken right after a read")

    // A status result carries a zero, finite distance.
    `APSP_ASSERT_IMP(a_status_payload, rsp_valid && rsp_is_status, (rsp_distance == '0) && !rsp_distance_infinite, "status result with distance payload")

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .req_kind              (req.kind),
    .req_last_load         (req.last_load),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_distance          (rsp.distance),
    .rsp_distance_infinite (rsp.distance_infinite),
    .rsp_is_status         (rsp.is_status)
);
